[design/edd_pkg.sv]
// shared types, constants and arithmetic helpers of the error diffusion dither core
// no dependencies; used by the interfaces and every module of the core
`timescale 1ns / 1ps
`default_nettype none

package edd_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int COL_W       = $clog2(MAX_COLUMNS);
   localparam int WCNT_W      = $clog2(MAX_COLUMNS + 1);
   localparam int ADDR_W      = COL_W + 1;
   localparam int ROW_W       = 12;
   localparam int GREY_W      = 4;
   localparam int OUT_COL_W   = 8;
   localparam int COLCFG_W    = 9;
   localparam int CSR_DATA_W  = 12;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [COLCFG_W-1:0] RESET_COLUMNS = 9'd168;
   localparam logic [ROW_W-1:0]    RESET_ROWS    = 12'd144;
   localparam logic [7:0]          THRESHOLD     = 8'd127;
   localparam logic [7:0]          FULL_LEVEL    = 8'd255;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;
   localparam logic REG_COLUMNS = 1'b0;
   localparam logic REG_ROWS    = 1'b1;

   typedef enum logic [2:0] {
      OP_FILL   = 3'b001,
      OP_LOAD   = 3'b010,
      OP_DECIDE = 3'b100
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [COL_W-1:0]  col;
      logic [ROW_W-1:0]  row;
      logic [GREY_W-1:0] grey;
      logic              below;
      logic              store_self;
      logic              has_right;
      logic              last_col;
      logic              swap;
      logic              frame_end;
      logic              last;
   } op_type;

   typedef logic signed [8:0] err_type;
   typedef logic signed [7:0] amt_type;

   function automatic logic [7:0] level(input logic [GREY_W-1:0] nib);
      return {nib, nib};
   endfunction

   // weighted error over 16, truncated toward zero
   function automatic amt_type part_of(input err_type err, input logic [2:0] wt);
      logic signed [11:0] prod;
      logic signed [11:0] biased;
      prod   = 12'(err) * $signed({9'd0, wt});
      biased = (prod < 0) ? prod + 12'sd15 : prod;
      return biased[11:4];
   endfunction

   // add to the 8-bit level, clamp, keep the top nibble
   function automatic logic [GREY_W-1:0] spread(input logic [GREY_W-1:0] nib,
                                                input amt_type amt);
      logic signed [9:0] sum;
      sum = $signed({2'b00, level(nib)}) + 10'(amt);
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed({2'b00, FULL_LEVEL})) begin
         return FULL_LEVEL[7:4];
      end else begin
         return sum[7:4];
      end
   endfunction

endpackage

`default_nettype wire

[design/edd_ifs.sv]
// valid/ready channel interfaces of the dither core: pixel requests, results, register writes
// depends on edd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface edd_req_if import edd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [GREY_W-1:0] grey_in;

   modport source (output valid, kind, grey_in, input ready);
   modport sink (input valid, kind, grey_in, output ready);
endinterface

interface edd_rsp_if import edd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 black;
   logic [OUT_COL_W-1:0] pixel_column;
   logic [ROW_W-1:0]     pixel_row;
   logic                 frame_end;
   logic                 last;

   modport source (output valid, black, pixel_column, pixel_row, frame_end, last,
                   input ready);
   modport sink (input valid, black, pixel_column, pixel_row, frame_end, last,
                 output ready);
endinterface

interface edd_csr_if import edd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/error_diffusion_dither_core.sv]
// error diffusion dither core: 4-bit grey raster in, one black/white decision per pixel out
// decisions pass through the op queue and leave from the result register
// throughput: one transaction per cycle while the queue has room and the result register drains;
//    a row-end transaction with two results holds off the next until its second decide is queued
// reset: synchronous, active high; clears counters and queue, loads 168 columns and 144 rows;
//    the row memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither_core import edd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   edd_req_if.sink   req_chan,
   edd_rsp_if.source rsp_chan,
   edd_csr_if.sink   csr_chan
);

   op_type push_op, pop_op;
   logic   push_valid, push_ready, pop_valid, pop_ready, restart;

   edd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .restart    (restart)
   );

   edd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_op    (push_op),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_op     (pop_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   edd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_op    (pop_op),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .restart   (restart),
      .rsp       (rsp_chan)
   );

`ifndef SYNTHESIS
   a_split_follows: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_ready && push_op.kind == OP_DECIDE && !push_op.last
      |=> push_valid && push_op.kind == OP_DECIDE && push_op.last_col)
      else $error("second decide of a row-end transaction missing");

   a_swap_at_row_end: assert property (@(posedge clock) disable iff (reset)
      push_valid && push_op.swap |-> push_op.last_col)
      else $error("bank swap away from the last column");

   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_end |-> rsp_chan.last)
      else $error("frame end on a result that is not the last of its transaction");
`endif

endmodule

`default_nettype wire

[design/edd_front.sv]
// front end: register file, raster counters and classification of each transaction into ops
// depends on edd_pkg and edd_ifs
`timescale 1ns / 1ps
`default_nettype none

module edd_front import edd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   edd_req_if.sink    req,
   edd_csr_if.sink    csr,
   output op_type     push_op,
   output logic       push_valid,
   input  wire logic  push_ready,
   output logic       restart
);

   logic [COLCFG_W-1:0] cols_ff;
   logic [ROW_W-1:0]    rows_ff;
   logic [COL_W-1:0]    ac_ff, ac_in;
   logic [ROW_W-1:0]    ar_ff, ar_in;
   logic [COL_W-1:0]    dc_ff, dc_in;
   logic                sec_v_ff, sec_v_in;
   op_type              sec_op_ff, sec_op_in;

   logic [WCNT_W-1:0]   w_cols;
   logic [ROW_W-1:0]    h_rows;
   logic [COL_W-1:0]    last_idx;
   logic                drain, a_last, d_last, acc;
   op_type              op1, op2;
   logic                op1_v, op2_v;

   assign csr.ready = 1'b1;
   assign restart   = csr.valid;
   assign req.ready = push_ready && !sec_v_ff;
   assign acc       = req.valid && req.ready;

   always_comb begin
      if (cols_ff == '0) begin
         w_cols = WCNT_W'(1);
      end else if (int'(cols_ff) > MAX_COLUMNS) begin
         w_cols = WCNT_W'(MAX_COLUMNS);
      end else begin
         w_cols = WCNT_W'(cols_ff);
      end
      h_rows   = (rows_ff == '0) ? ROW_W'(1) : rows_ff;
      last_idx = COL_W'(w_cols - WCNT_W'(1));
   end

   assign drain  = ar_ff >= h_rows;
   assign a_last = ac_ff == last_idx;
   assign d_last = dc_ff == last_idx;

   always_comb begin
      op1   = '0;
      op2   = '0;
      op1_v = 1'b0;
      op2_v = 1'b0;
      ac_in = ac_ff;
      ar_in = ar_ff;
      dc_in = dc_ff;
      if (req.kind == KIND_PIXEL) begin
         if (!drain && (WCNT_W'(ac_ff) < w_cols)) begin
            op1.grey = req.grey_in;
            op1.row  = ar_ff - ROW_W'(1);
            op1_v    = 1'b1;
            if (ar_ff == '0) begin
               op1.kind     = OP_FILL;
               op1.col      = ac_ff;
               op1.last_col = a_last;
               op1.swap     = a_last;
            end else if (ac_ff == '0 && !a_last) begin
               op1.kind = OP_LOAD;
            end else if (ac_ff == '0) begin
               op1.kind       = OP_DECIDE;
               op1.col        = '0;
               op1.below      = 1'b1;
               op1.store_self = 1'b1;
               op1.last_col   = 1'b1;
               op1.swap       = 1'b1;
               op1.last       = 1'b1;
            end else begin
               op1.kind      = OP_DECIDE;
               op1.col       = ac_ff - COL_W'(1);
               op1.below     = 1'b1;
               op1.has_right = 1'b1;
               op1.last      = !a_last;
               op2.kind      = OP_DECIDE;
               op2.col       = ac_ff;
               op2.row       = op1.row;
               op2.below     = 1'b1;
               op2.last_col  = 1'b1;
               op2.swap      = 1'b1;
               op2.last      = 1'b1;
               op2_v         = a_last;
            end
            if (a_last) begin
               ac_in = '0;
               ar_in = ar_ff + ROW_W'(1);
               dc_in = '0;
            end else begin
               ac_in = ac_ff + COL_W'(1);
            end
         end
      end else begin
         if (drain && (WCNT_W'(dc_ff) < w_cols)) begin
            op1.kind      = OP_DECIDE;
            op1.col       = dc_ff;
            op1.row       = h_rows - ROW_W'(1);
            op1.has_right = !d_last;
            op1.last_col  = d_last;
            op1.frame_end = d_last;
            op1.last      = 1'b1;
            op1_v         = 1'b1;
            if (d_last) begin
               ac_in = '0;
               ar_in = '0;
               dc_in = '0;
            end else begin
               dc_in = dc_ff + COL_W'(1);
            end
         end
      end
   end

   always_comb begin
      push_valid = sec_v_ff || (acc && op1_v);
      push_op    = sec_v_ff ? sec_op_ff : op1;
      sec_v_in   = sec_v_ff ? !push_ready : (acc && op2_v);
      sec_op_in  = sec_v_ff ? sec_op_ff : op2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= RESET_COLUMNS;
         rows_ff  <= RESET_ROWS;
         ac_ff    <= '0;
         ar_ff    <= '0;
         dc_ff    <= '0;
         sec_v_ff <= 1'b0;
      end else if (csr.valid) begin
         case (csr.index)
            REG_COLUMNS: cols_ff <= csr.data[COLCFG_W-1:0];
            REG_ROWS:    rows_ff <= csr.data[ROW_W-1:0];
            default:     cols_ff <= cols_ff;
         endcase
         ac_ff    <= '0;
         ar_ff    <= '0;
         dc_ff    <= '0;
         sec_v_ff <= 1'b0;
      end else begin
         if (acc) begin
            ac_ff <= ac_in;
            ar_ff <= ar_in;
            dc_ff <= dc_in;
         end
         sec_v_ff <= sec_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_op_ff <= sec_op_in;
   end

endmodule

`default_nettype wire

[design/edd_queue.sv]
// short op queue between the front end and the back end
// depends on edd_pkg
`timescale 1ns / 1ps
`default_nettype none

module edd_queue import edd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  op_type    push_op,
   input  wire logic push_valid,
   output logic      push_ready,
   output op_type    pop_op,
   output logic      pop_valid,
   input  wire logic pop_ready
);

   op_type              slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QDEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

[design/edd_back.sv]
// back end: two-bank row memory, error spread window and result register
// depends on edd_pkg and edd_ifs
`timescale 1ns / 1ps
`default_nettype none

module edd_back import edd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  op_type    pop_op,
   input  wire logic pop_valid,
   output logic      pop_ready,
   input  wire logic restart,
   edd_rsp_if.source rsp
);

   logic [GREY_W-1:0]    row_mem [2 * MAX_COLUMNS];
   logic [GREY_W-1:0]    rd_data_ff;
   logic                 byp_v_ff;
   logic [GREY_W-1:0]    byp_d_ff;
   logic                 pend_v_ff, pend_v_in;
   logic [ADDR_W-1:0]    pend_addr_ff;
   logic [GREY_W-1:0]    pend_d_ff;
   logic [COL_W-1:0]     dptr_ff, dptr_in;
   logic                 bank_ff, bank_in;
   logic [GREY_W-1:0]    wm1_ff, w0_ff;
   amt_type              carry_ff;

   logic                 rsp_v_ff, rsp_v_in;
   logic                 black_ff;
   logic [OUT_COL_W-1:0] col_ff;
   logic [ROW_W-1:0]     row_ff;
   logic                 fend_ff, last_ff;

   logic                 is_dec, slot_free, exec;
   logic [ADDR_W-1:0]    raddr, cur_addr, waddr, op_waddr;
   logic                 we, op_we, set_pend;
   logic [GREY_W-1:0]    wdata, op_wdata;
   logic [GREY_W-1:0]    cur_nib, adj_nib, val_d, fin_m1, new_d, new_r;
   logic [7:0]           g;
   logic                 blk;
   err_type              e;
   amt_type              amt;

   assign is_dec    = pop_op.kind == OP_DECIDE;
   assign slot_free = !rsp_v_ff || rsp.ready;
   assign pop_ready = is_dec ? slot_free : 1'b1;
   assign exec      = pop_valid && pop_ready;

   always_comb begin
      dptr_in = dptr_ff;
      if (restart) begin
         dptr_in = '0;
      end else if (exec && is_dec) begin
         dptr_in = pop_op.last_col ? '0 : pop_op.col + COL_W'(1);
      end
      bank_in = (exec && pop_op.swap) ? !bank_ff : bank_ff;
   end

   assign raddr    = {bank_in, dptr_in};
   assign cur_addr = {bank_ff, dptr_ff};

   // current row value with the pending write and last write forwarded
   always_comb begin
      if (pend_v_ff && pend_addr_ff == cur_addr) begin
         cur_nib = pend_d_ff;
      end else if (byp_v_ff) begin
         cur_nib = byp_d_ff;
      end else begin
         cur_nib = rd_data_ff;
      end
      amt     = (pop_op.col == '0) ? amt_type'(0) : carry_ff;
      adj_nib = spread(cur_nib, amt);
      g       = level(adj_nib);
      blk     = g > THRESHOLD;
      e       = $signed({1'b0, g}) - (blk ? $signed({1'b0, FULL_LEVEL}) : 9'sd0);
      val_d   = pop_op.store_self ? pop_op.grey : w0_ff;
      fin_m1  = spread(wm1_ff, part_of(e, 3'd3));
      new_d   = spread(val_d, part_of(e, 3'd5));
      new_r   = spread(pop_op.grey, part_of(e, 3'd1));
   end

   always_comb begin
      op_we    = 1'b0;
      op_waddr = '0;
      op_wdata = '0;
      set_pend = 1'b0;
      if (exec) begin
         case (pop_op.kind)
            OP_FILL: begin
               op_we    = 1'b1;
               op_waddr = {!bank_ff, pop_op.col};
               op_wdata = pop_op.grey;
            end
            OP_DECIDE: begin
               if (pop_op.below && pop_op.col != '0) begin
                  op_we    = 1'b1;
                  op_waddr = {!bank_ff, pop_op.col - COL_W'(1)};
                  op_wdata = fin_m1;
                  set_pend = pop_op.last_col;
               end else if (pop_op.below && pop_op.last_col) begin
                  op_we    = 1'b1;
                  op_waddr = {!bank_ff, pop_op.col};
                  op_wdata = new_d;
               end
            end
            default: op_we = 1'b0;
         endcase
      end
      we    = op_we || pend_v_ff;
      waddr = op_we ? op_waddr : pend_addr_ff;
      wdata = op_we ? op_wdata : pend_d_ff;
      if (set_pend) begin
         pend_v_in = 1'b1;
      end else if (!op_we) begin
         pend_v_in = 1'b0;
      end else begin
         pend_v_in = pend_v_ff;
      end
   end

   always_comb begin
      rsp_v_in = rsp_v_ff && !rsp.ready;
      if (exec && is_dec) begin
         rsp_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         row_mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= row_mem[raddr];
      byp_v_ff   <= we && (waddr == raddr);
      byp_d_ff   <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         dptr_ff   <= '0;
         bank_ff   <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         dptr_ff   <= dptr_in;
         bank_ff   <= bank_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (set_pend) begin
         pend_addr_ff <= {!bank_ff, pop_op.col};
         pend_d_ff    <= new_d;
      end
      if (exec && pop_op.kind == OP_LOAD) begin
         w0_ff <= pop_op.grey;
      end
      if (exec && is_dec) begin
         carry_ff <= part_of(e, 3'd7);
         black_ff <= blk;
         col_ff   <= OUT_COL_W'(pop_op.col);
         row_ff   <= pop_op.row;
         fend_ff  <= pop_op.frame_end;
         last_ff  <= pop_op.last;
         if (pop_op.below) begin
            wm1_ff <= new_d;
            w0_ff  <= new_r;
         end
      end
   end

   assign rsp.valid        = rsp_v_ff;
   assign rsp.black        = black_ff;
   assign rsp.pixel_column = col_ff;
   assign rsp.pixel_row    = row_ff;
   assign rsp.frame_end    = fend_ff;
   assign rsp.last         = last_ff;

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench of the error diffusion dither core: pixel frames and flush ticks in, decisions checked
// against an in-bench dither predictor; depends on edd_pkg, the edd channel interfaces and the core
`timescale 1ns / 1ps

module tb;
   import edd_pkg::*;

   localparam int ITEM_TARGET = 1850;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic              kind;
      logic [GREY_W-1:0] grey;
   } pixel_item_t;

   typedef struct packed {
      logic                 black;
      logic [OUT_COL_W-1:0] pixel_column;
      logic [ROW_W-1:0]     pixel_row;
      logic                 frame_end;
      logic                 last;
   } decision_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_kind = KIND_PIXEL;
   logic [GREY_W-1:0]     req_grey = '0;
   logic                  rsp_ready = 1'b0;
   logic                  csr_valid = 1'b0;
   logic                  csr_index = REG_COLUMNS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   logic hold_kick = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;
   int   idle_mode = 0;
   int   fail_cnt = 0;
   int   n_real = 0;

   pixel_item_t pending_pixels[$];
   decision_t   expected_decisions[$];

   // predictor state
   logic [GREY_W-1:0]   row_now [MAX_COLUMNS];
   logic [GREY_W-1:0]   row_next [MAX_COLUMNS];
   int                  in_col = 0;
   int                  in_row = 0;
   int                  out_col = 0;
   logic [COLCFG_W-1:0] cols_reg = RESET_COLUMNS;
   logic [ROW_W-1:0]    rows_reg = RESET_ROWS;

   edd_req_if req_chan ();
   edd_rsp_if rsp_chan ();
   edd_csr_if csr_chan ();

   assign req_chan.valid   = req_valid;
   assign req_chan.kind    = req_kind;
   assign req_chan.grey_in = req_grey;
   assign rsp_chan.ready   = rsp_ready;
   assign csr_chan.valid   = csr_valid;
   assign csr_chan.index   = csr_index;
   assign csr_chan.data    = csr_data;

   error_diffusion_dither_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_cols(input int v);
      return (v < 1) ? 1 : ((v > MAX_COLUMNS) ? MAX_COLUMNS : v);
   endfunction

   function automatic int eff_rows(input int v);
      return (v < 1) ? 1 : v;
   endfunction

   function automatic logic [GREY_W-1:0] nudge_level(input logic [GREY_W-1:0] nib,
                                                     input int amt);
      int sum;
      sum = int'(nib) * 17 + amt;
      if (sum < 0) begin
         sum = 0;
      end else if (sum > 255) begin
         sum = 255;
      end
      return GREY_W'(sum >> 4);
   endfunction

   // threshold one pixel and push its error to the right and into the next row
   function automatic decision_t decide_pixel(input int col, input int row, input int w,
                                              input bit below, input bit fend);
      int        lvl;
      int        err;
      bit        blk;
      bit        rgt;
      decision_t d;
      lvl = int'(row_now[col]) * 17;
      blk = lvl > 127;
      err = blk ? lvl - 255 : lvl;
      rgt = col + 1 < w;
      if (rgt) row_now[col+1] = nudge_level(row_now[col+1], (7 * err) / 16);
      if (below) begin
         if (col > 0) row_next[col-1] = nudge_level(row_next[col-1], (3 * err) / 16);
         row_next[col] = nudge_level(row_next[col], (5 * err) / 16);
         if (rgt) row_next[col+1] = nudge_level(row_next[col+1], err / 16);
      end
      d.black        = blk;
      d.pixel_column = OUT_COL_W'(col);
      d.pixel_row    = ROW_W'(row);
      d.frame_end    = fend;
      d.last         = 1'b0;
      return d;
   endfunction

   function automatic void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
   endfunction

   function automatic void dither_predict(input logic kind, input logic [GREY_W-1:0] grey);
      int        w;
      int        h;
      int        c;
      int        n;
      int        i;
      decision_t got [2];
      w = eff_cols(int'(cols_reg));
      h = eff_rows(int'(rows_reg));
      n = 0;
      if (kind == KIND_PIXEL) begin
         c = in_col;
         if (in_row < h && c < w) begin
            row_next[c] = grey;
            if (in_row > 0) begin
               if (c >= 1) begin
                  got[n] = decide_pixel(c - 1, in_row - 1, w, 1'b1, 1'b0);
                  n++;
               end
               if (c + 1 >= w) begin
                  got[n] = decide_pixel(w - 1, in_row - 1, w, 1'b1, 1'b0);
                  n++;
               end
            end
            if (c + 1 >= w) begin
               row_now = row_next;
               in_col  = 0;
               in_row++;
               out_col = 0;
            end else begin
               in_col = c + 1;
            end
         end
      end else begin
         c = out_col;
         if (in_row >= h && c < w) begin
            got[n] = decide_pixel(c, h - 1, w, 1'b0, c + 1 >= w);
            n++;
            if (c + 1 >= w) restart_frame();
            else out_col = c + 1;
         end
      end
      if (n > 0) got[n-1].last = 1'b1;
      for (i = 0; i < n; i++) expected_decisions.push_back(got[i]);
   endfunction

   function automatic int sender_gap_pct();
      return (idle_mode == 1) ? 78 : ((idle_mode == 3) ? 37 : 0);
   endfunction

   function automatic int receiver_stall_pct();
      return (idle_mode == 2) ? 78 : ((idle_mode == 3) ? 37 : 0);
   endfunction

   // request driver
   always @(posedge clock) begin
      pixel_item_t it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_chan.ready) dither_predict(req_kind, req_grey);
         if (!req_valid || req_chan.ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_gap_pct()) begin
               it = pending_pixels.pop_front();
               req_valid <= 1'b1;
               req_kind  <= it.kind;
               req_grey  <= it.grey;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      decision_t got;
      decision_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct());
         if (rsp_chan.valid && rsp_ready) begin
            got.black        = rsp_chan.black;
            got.pixel_column = rsp_chan.pixel_column;
            got.pixel_row    = rsp_chan.pixel_row;
            got.frame_end    = rsp_chan.frame_end;
            got.last         = rsp_chan.last;
            if (expected_decisions.size() == 0) begin
               fail_cnt++;
               if (fail_cnt <= 10)
                  $display("%0t: unexpected result black=%0d col=%0d row=%0d end=%0d last=%0d",
                           $realtime, got.black, got.pixel_column, got.pixel_row,
                           got.frame_end, got.last);
            end else begin
               want = expected_decisions.pop_front();
               if (got.black !== want.black || got.pixel_column !== want.pixel_column ||
                   got.pixel_row !== want.pixel_row || got.frame_end !== want.frame_end ||
                   got.last !== want.last) begin
                  fail_cnt++;
                  if (fail_cnt <= 10)
                     $display("%0t: mismatch exp black=%0d col=%0d row=%0d end=%0d last=%0d, %s",
                              $realtime, want.black, want.pixel_column, want.pixel_row,
                              want.frame_end, want.last,
                              $sformatf("got black=%0d col=%0d row=%0d end=%0d last=%0d",
                                        got.black, got.pixel_column, got.pixel_row,
                                        got.frame_end, got.last));
               end
            end
         end
      end
   end

   task automatic push_item(input logic kind, input int grey, input bit real_item);
      pixel_item_t it;
      it.kind = kind;
      it.grey = GREY_W'(grey);
      pending_pixels.push_back(it);
      if (real_item) n_real++;
   endtask

   function automatic int rand_grey();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 15 : 0;
      return $urandom_range(15);
   endfunction

   // one frame in raster order with its drain; cut >= 0 stops after that many pixels
   task automatic queue_frame(input int w, input int h, input int cut);
      int total;
      int n_px;
      int i;
      total = w * h;
      n_px  = (cut >= 0 && cut < total) ? cut : total;
      for (i = 0; i < n_px; i++) begin
         if ($urandom_range(19) == 0) push_item(KIND_FLUSH, rand_grey(), 1'b0);
         push_item(KIND_PIXEL, rand_grey(), 1'b1);
      end
      if (n_px == total) begin
         for (i = 0; i < w; i++) begin
            if ($urandom_range(19) == 0) push_item(KIND_PIXEL, rand_grey(), 1'b0);
            push_item(KIND_FLUSH, rand_grey(), 1'b1);
         end
         if ($urandom_range(3) == 0) push_item(KIND_FLUSH, rand_grey(), 1'b0);
      end
   endtask

   task automatic settle();
      while (pending_pixels.size() != 0 || req_valid) @(posedge clock);
      while (expected_decisions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == REG_COLUMNS) cols_reg = COLCFG_W'(value);
      else rows_reg = ROW_W'(value);
      restart_frame();
      @(posedge clock);
   endtask

   initial begin
      int ph;
      int cols_val;
      int rows_val;
      int w;
      int h;
      int nfr;
      int f;
      int cut;
      for (int i = 0; i < MAX_COLUMNS; i++) begin
         row_now[i]  = '0;
         row_next[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: thresholds, ignored ticks and pixels, zero register values
      write_reg(REG_COLUMNS, 3);
      write_reg(REG_ROWS, 2);
      push_item(KIND_FLUSH, 15, 1'b0);
      push_item(KIND_PIXEL, 0, 1'b1);
      push_item(KIND_PIXEL, 15, 1'b1);
      push_item(KIND_PIXEL, 8, 1'b1);
      push_item(KIND_PIXEL, 7, 1'b1);
      push_item(KIND_PIXEL, 15, 1'b1);
      push_item(KIND_PIXEL, 0, 1'b1);
      push_item(KIND_PIXEL, 5, 1'b0);
      repeat (3) push_item(KIND_FLUSH, 0, 1'b1);
      push_item(KIND_FLUSH, 10, 1'b0);
      settle();
      write_reg(REG_COLUMNS, 0);
      write_reg(REG_ROWS, 0);
      push_item(KIND_PIXEL, 15, 1'b1);
      push_item(KIND_PIXEL, 9, 1'b0);
      push_item(KIND_FLUSH, 3, 1'b1);
      push_item(KIND_PIXEL, 0, 1'b1);
      push_item(KIND_FLUSH, 12, 1'b1);
      settle();
      write_reg(REG_ROWS, 3);
      write_reg(REG_COLUMNS, 2);
      push_item(KIND_PIXEL, 8, 1'b1);
      push_item(KIND_PIXEL, 7, 1'b1);
      push_item(KIND_PIXEL, 15, 1'b1);
      push_item(KIND_PIXEL, 0, 1'b1);
      push_item(KIND_PIXEL, 3, 1'b1);
      push_item(KIND_PIXEL, 12, 1'b1);
      repeat (2) push_item(KIND_FLUSH, 6, 1'b1);
      settle();

      ph = 0;
      while (n_real < ITEM_TARGET) begin
         ph++;
         idle_mode <= ph % 4;
         if (ph == 2) begin
            write_reg(REG_COLUMNS, 511);
            write_reg(REG_ROWS, 1);
            queue_frame(MAX_COLUMNS, 1, -1);
         end else if (ph == 4) begin
            write_reg(REG_ROWS, 4095);
            write_reg(REG_COLUMNS, 256);
            queue_frame(MAX_COLUMNS, 4095, 2 * MAX_COLUMNS + 8);
            hold_kick <= ~hold_kick;
         end else begin
            cols_val = ($urandom_range(7) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 10);
            rows_val = $urandom_range(0, 5);
            if ($urandom_range(1)) begin
               write_reg(REG_COLUMNS, cols_val);
               write_reg(REG_ROWS, rows_val);
            end else begin
               write_reg(REG_ROWS, rows_val);
               write_reg(REG_COLUMNS, cols_val);
            end
            w   = eff_cols(cols_val);
            h   = eff_rows(rows_val);
            nfr = $urandom_range(1, 3);
            for (f = 0; f < nfr; f++) begin
               cut = ($urandom_range(4) == 0) ? $urandom_range(0, w * h - 1) : -1;
               queue_frame(w, h, cut);
               if (cut >= 0) break;
            end
         end
         settle();
      end

      settle();
      repeat (12) @(posedge clock);
      if (fail_cnt == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[error_diffusion_dither_core.f]
design/edd_pkg.sv
design/edd_ifs.sv
design/edd_front.sv
design/edd_queue.sv
design/edd_back.sv
design/error_diffusion_dither_core.sv
tb/tb.sv
